/* src/bdeq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int CAP_W         = 11;
    localparam int VAL_W         = 32;
    localparam int COUNT_W       = 11;

    localparam logic [CAP_W-1:0] CAP_RESET   = 11'd1024;
    localparam logic [VAL_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    // Per-request outcome from the pointer unit
    typedef struct packed {
        logic ok;
        logic wr_en;
        logic is_empty;
        logic is_full;
    } bdeq_stat_t;

endpackage

`default_nettype wire

/* src/bdeq_ptr.sv */
// Front/rear index and occupancy tracking for the deque ring buffer.
// Decides each request and gives the ring write slot and the two read slots.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_ptr
    import bdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_fire,
    input  wire req_t                       req_type,
    input  wire logic [CAP_W-1:0]           capacity,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [$clog2(DEPTH)-1:0]        rd_front_addr,
    output logic [$clog2(DEPTH)-1:0]        rd_rear_addr,
    output bdeq_stat_t                      stat,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = (CW > CAP_W) ? CW : CAP_W;

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg, rear_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [W-1:0]  cap_eff;
    logic          full_before;
    logic          empty_before;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign cap_eff      = (W'(capacity) > W'(DEPTH)) ? W'(DEPTH) : W'(capacity);
    assign full_before  = W'(occ_reg) >= cap_eff;
    assign empty_before = (occ_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        occ_next    = occ_reg;
        wr_addr     = rear_reg;
        stat.ok     = 1'b0;
        stat.wr_en  = 1'b0;
        unique case (req_type)
            REQ_PUSH_FRONT:
            begin
                wr_addr = wrap_dec(front_reg);
                if (!full_before)
                begin
                    front_next = wrap_dec(front_reg);
                    occ_next   = occ_reg + 1'b1;
                    stat.ok    = 1'b1;
                    stat.wr_en = 1'b1;
                end
            end
            REQ_PUSH_BACK:
            begin
                wr_addr = rear_reg;
                if (!full_before)
                begin
                    rear_next  = wrap_inc(rear_reg);
                    occ_next   = occ_reg + 1'b1;
                    stat.ok    = 1'b1;
                    stat.wr_en = 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (!empty_before)
                begin
                    front_next = wrap_inc(front_reg);
                    occ_next   = occ_reg - 1'b1;
                    stat.ok    = 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                if (!empty_before)
                begin
                    rear_next = wrap_dec(rear_reg);
                    occ_next  = occ_reg - 1'b1;
                    stat.ok   = 1'b1;
                end
            end
            default:
            begin
                stat.ok = 1'b0;
            end
        endcase
        // Flags describe the state after this request
        stat.is_empty = (occ_next == '0);
        stat.is_full  = W'(occ_next) >= cap_eff;
    end

    // Slots read to report the state after this request
    assign rd_front_addr = front_next;
    assign rd_rear_addr  = wrap_dec(rear_next);
    assign count         = occ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (req_fire)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
        end
    end

endmodule

`default_nettype wire

/* src/bounded_double_ended_queue.sv */
// A request beat's result goes from the synchronous read of the single-port-write ring into
// the read-data stage, then into the output register.
// Throughput: one request per cycle while results are taken; the read-data stage and the
// output register form a two-deep pipe, so a stalled output holds at most two requests.
// Reset clears indices and count at once; ring contents are left as they are and never
// reported before being written. Capacity resets to 1024.
// Depends on bdeq_pkg and bdeq_ptr.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] push_value
    input  wire logic [7:0]        s_tuser,   // [1:0] req_type
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [79:0]            m_tdata,   // [0] accepted, [1] is_empty, [2] is_full,
                                              // [13:3] entry_count, [45:14] front_value,
                                              // [77:46] rear_value
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = (CW > COUNT_W) ? CW : COUNT_W;

    logic [CAP_W-1:0] capacity_reg;

    logic             fire;
    logic             out_move;
    req_t             req_type;
    logic [VAL_W-1:0] push_value;

    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_front_addr;
    logic [AW-1:0]    rd_rear_addr;
    bdeq_stat_t       stat;
    logic [CW-1:0]    count;

    logic [VAL_W-1:0] ring [DEPTH];
    logic [VAL_W-1:0] rd_front_reg;
    logic [VAL_W-1:0] rd_rear_reg;

    // Read-data stage
    logic             busy_reg, busy_next;
    bdeq_stat_t       stat_reg;
    logic [CW-1:0]    count_reg;
    logic             fwd_front_reg;
    logic             fwd_rear_reg;
    logic [VAL_W-1:0] push_reg;

    logic [VAL_W-1:0] front_value;
    logic [VAL_W-1:0] rear_value;
    logic [W-1:0]     count_ext;

    logic             out_valid_reg;
    logic [79:0]      out_data_reg;

    assign req_type   = req_t'(s_tuser[1:0]);
    assign push_value = s_tdata;
    assign out_move   = busy_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !busy_reg || out_move;
    assign fire       = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    bdeq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_fire      (fire),
        .req_type      (req_type),
        .capacity      (capacity_reg),
        .wr_addr       (wr_addr),
        .rd_front_addr (rd_front_addr),
        .rd_rear_addr  (rd_rear_addr),
        .stat          (stat),
        .count         (count)
    );

    // Ring: one write, two reads, old data on a same-slot collision
    always_ff @(posedge clk)
    begin
        if (fire && stat.wr_en)
            ring[wr_addr] <= push_value;
        if (fire)
        begin
            rd_front_reg <= ring[rd_front_addr];
            rd_rear_reg  <= ring[rd_rear_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            stat_reg      <= stat;
            count_reg     <= count;
            push_reg      <= push_value;
            fwd_front_reg <= stat.wr_en && (wr_addr == rd_front_addr);
            fwd_rear_reg  <= stat.wr_en && (wr_addr == rd_rear_addr);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (fire)
            busy_next = 1'b1;
        else if (out_move)
            busy_next = 1'b0;
    end

    always_comb
    begin
        if (stat_reg.is_empty)
            front_value = EMPTY_VALUE;
        else if (fwd_front_reg)
            front_value = push_reg;
        else
            front_value = rd_front_reg;

        if (stat_reg.is_empty)
            rear_value = EMPTY_VALUE;
        else if (fwd_rear_reg)
            rear_value = push_reg;
        else
            rear_value = rd_rear_reg;
    end

    assign count_ext = W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (out_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move)
            out_data_reg <= {2'b00, rear_value, front_value, count_ext[COUNT_W-1:0],
                             stat_reg.is_full, stat_reg.is_empty, stat_reg.ok};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* src/bdeq_chk.sv */
// Port-level checks for the bounded double-ended queue, bound to the top level.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_chk
    import bdeq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);

    // Result beat held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Empty queue reports both end values as the empty marker
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> (m_tdata[45:14] == EMPTY_VALUE)
                                  && (m_tdata[77:46] == EMPTY_VALUE))
        else $error("empty result with end values set");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[13:3] == '0)
        else $error("empty result with nonzero count");

endmodule

bind bounded_double_ended_queue bdeq_chk u_bdeq_chk (.*);

`default_nettype wire

/* tb/bounded_double_ended_queue_test.sv */
// Self-checking bench for bounded_double_ended_queue: directed rows, then random
// push/pop traffic across several capacities, each result checked against a local deque.
// Depends on bdeq_pkg and the bounded_double_ended_queue RTL.
`timescale 1ns / 1ps

module bounded_double_ended_queue_test;
    import bdeq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int SETTLE_CYC = 6;
    localparam int HOLD_CYC   = 400;
    localparam int WATCHDOG   = 5000;

    // m_tdata layout, lowest bit last
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] rear;
        logic [31:0] front;
        logic [10:0] count;
        logic        full;
        logic        empty;
        logic        ok;
    } outcome_t;

    typedef struct {
        bit          is_cfg;
        logic [10:0] cap_val;
        req_t        kind;
        logic [31:0] val;
        bit          typed;
        outcome_t    exp;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [31:0] push_value
    logic [7:0]        s_tuser;   // [1:0] req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [79:0]       m_tdata;   // [0] accepted, [1] is_empty, [2] is_full,
                                  // [13:3] entry_count, [45:14] front_value,
                                  // [77:46] rear_value
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_wdata;

    // travel alongside each request beat
    logic              typed_flag;
    outcome_t          typed_exp;

    // local copy of the deque
    logic [31:0]       ring [DEPTH];
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    int unsigned       held;
    logic [CAP_W-1:0]  cap_reg;

    outcome_t          due_outcomes [$];
    int                bad_outcomes;
    int                quiet_cycles;
    bit                steady;
    bit                stall_sink;

    bounded_double_ended_queue #(.DEPTH(DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one request to the local deque and returns the outcome it should report.
    function automatic outcome_t next_outcome(req_t kind, logic [31:0] val);
        outcome_t         r;
        int unsigned      lim;
        bit               full_before;
        logic [IDX_W-1:0] last_slot;
        r = '0;
        lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        full_before = (held >= lim);
        case (kind)
            REQ_PUSH_FRONT:
                if (!full_before)
                begin
                    head_slot = head_slot - 1'b1;
                    ring[head_slot] = val;
                    held++;
                    r.ok = 1'b1;
                end
            REQ_PUSH_BACK:
                if (!full_before)
                begin
                    ring[tail_slot] = val;
                    tail_slot = tail_slot + 1'b1;
                    held++;
                    r.ok = 1'b1;
                end
            REQ_POP_FRONT:
                if (held != 0)
                begin
                    head_slot = head_slot + 1'b1;
                    held--;
                    r.ok = 1'b1;
                end
            default:
                if (held != 0)
                begin
                    tail_slot = tail_slot - 1'b1;
                    held--;
                    r.ok = 1'b1;
                end
        endcase
        last_slot = tail_slot - 1'b1;
        r.empty = (held == 0);
        r.full  = (held >= lim);
        r.count = held[10:0];
        r.front = r.empty ? EMPTY_VALUE : ring[head_slot];
        r.rear  = r.empty ? EMPTY_VALUE : ring[last_slot];
        return r;
    endfunction

    function automatic outcome_t outcome_of(bit ok, bit empty, bit full, int count,
                                            logic [31:0] front, logic [31:0] rear);
        outcome_t r;
        r = '0;
        r.ok    = ok;
        r.empty = empty;
        r.full  = full;
        r.count = count[10:0];
        r.front = front;
        r.rear  = rear;
        return r;
    endfunction

    function automatic row_t blank_row();
        row_t r;
        r.is_cfg  = 1'b0;
        r.cap_val = '0;
        r.kind    = REQ_PUSH_FRONT;
        r.val     = '0;
        r.typed   = 1'b0;
        r.exp     = '0;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [10:0] v);
        row_t r;
        r = blank_row();
        r.is_cfg  = 1'b1;
        r.cap_val = v;
        return r;
    endfunction

    function automatic row_t req_row(req_t kind, logic [31:0] val);
        row_t r;
        r = blank_row();
        r.kind = kind;
        r.val  = val;
        return r;
    endfunction

    function automatic row_t chk_row(req_t kind, logic [31:0] val, outcome_t exp);
        row_t r;
        r = req_row(kind, val);
        r.typed = 1'b1;
        r.exp   = exp;
        return r;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pause_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request side monitor and result checker
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        outcome_t calc;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (due_outcomes.size() == 0)
                begin
                    bad_outcomes++;
                    if (bad_outcomes <= 10)
                        $display("%0t: unexpected result beat %h", $realtime, m_tdata);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (got.ok !== want.ok || got.empty !== want.empty
                        || got.full !== want.full || got.count !== want.count
                        || got.front !== want.front || got.rear !== want.rear)
                    begin
                        bad_outcomes++;
                        if (bad_outcomes <= 10)
                        begin
                            $display("%0t: exp ok=%0b empty=%0b full=%0b count=%0d %s",
                                     $realtime, want.ok, want.empty, want.full,
                                     want.count,
                                     $sformatf("front=%h rear=%h", want.front, want.rear));
                            $display("%0t: got ok=%0b empty=%0b full=%0b count=%0d %s",
                                     $realtime, got.ok, got.empty, got.full,
                                     got.count,
                                     $sformatf("front=%h rear=%h", got.front, got.rear));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                calc = next_outcome(req_t'(s_tuser[1:0]), s_tdata);
                due_outcomes.push_back(typed_flag ? typed_exp : calc);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("bounded_double_ended_queue: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pause_len();
            if (stall_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                stall_sink = 1'b0;
            end
            else if (gap == 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic offer(req_t kind, logic [31:0] val, bit typed, outcome_t exp);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= {6'b0, kind};
        s_tdata    <= val;
        typed_flag <= typed;
        typed_exp  <= exp;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_capacity(logic [10:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cap_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [10:0] cap, int beats, int push_pct, bit calm,
                             bit squeeze);
        req_t        kind;
        logic [31:0] val;
        int          pick;
        write_capacity(cap);
        steady = calm;
        if (squeeze)
            stall_sink = 1'b1;
        repeat (beats)
        begin
            if ($urandom_range(0, 99) < push_pct)
                kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else
                kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            pick = $urandom_range(0, 9);
            case (pick)
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            offer(kind, val, 1'b0, '0);
        end
        steady = 1'b0;
    endtask

    initial
    begin : main
        row_t plan [$];
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        typed_flag <= 1'b0;
        typed_exp  <= '0;
        head_slot = '0;
        tail_slot = '0;
        held = 0;
        cap_reg = CAP_RESET;
        bad_outcomes = 0;
        quiet_cycles = 0;
        steady = 1'b0;
        stall_sink = 1'b0;

        // empty pops, extremes at both ends
        plan.push_back(chk_row(REQ_POP_FRONT, 32'h0, outcome_of(0, 1, 0, 0, EMPTY_VALUE,
                                                                EMPTY_VALUE)));
        plan.push_back(chk_row(REQ_POP_BACK, 32'h0, outcome_of(0, 1, 0, 0, EMPTY_VALUE,
                                                               EMPTY_VALUE)));
        plan.push_back(chk_row(REQ_PUSH_BACK, 32'h7FFF_FFFF,
                               outcome_of(1, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
        plan.push_back(chk_row(REQ_PUSH_FRONT, 32'h8000_0000,
                               outcome_of(1, 0, 0, 2, 32'h8000_0000, 32'h7FFF_FFFF)));
        plan.push_back(req_row(REQ_PUSH_BACK, 32'h0000_0000));
        plan.push_back(req_row(REQ_PUSH_FRONT, 32'hFFFF_FFFF));
        plan.push_back(req_row(REQ_POP_BACK, 32'h0));
        plan.push_back(req_row(REQ_POP_FRONT, 32'h0));
        plan.push_back(req_row(REQ_POP_FRONT, 32'h0));
        plan.push_back(chk_row(REQ_POP_BACK, 32'h0, outcome_of(1, 1, 0, 0, EMPTY_VALUE,
                                                               EMPTY_VALUE)));
        // zero capacity: full and empty at once, all pushes refused
        plan.push_back(cfg_row(11'd0));
        plan.push_back(chk_row(REQ_PUSH_BACK, 32'h1234_5678,
                               outcome_of(0, 1, 1, 0, EMPTY_VALUE, EMPTY_VALUE)));
        plan.push_back(chk_row(REQ_PUSH_FRONT, 32'h1234_5678,
                               outcome_of(0, 1, 1, 0, EMPTY_VALUE, EMPTY_VALUE)));
        plan.push_back(chk_row(REQ_POP_FRONT, 32'h0, outcome_of(0, 1, 1, 0, EMPTY_VALUE,
                                                                EMPTY_VALUE)));
        plan.push_back(cfg_row(11'd2));
        plan.push_back(chk_row(REQ_PUSH_BACK, 32'd5, outcome_of(1, 0, 0, 1, 32'd5, 32'd5)));
        plan.push_back(chk_row(REQ_PUSH_FRONT, 32'd6, outcome_of(1, 0, 1, 2, 32'd6, 32'd5)));
        plan.push_back(chk_row(REQ_PUSH_BACK, 32'd7, outcome_of(0, 0, 1, 2, 32'd6, 32'd5)));
        // capacity below the count: still full, pops keep working
        plan.push_back(cfg_row(11'd1));
        plan.push_back(chk_row(REQ_PUSH_FRONT, 32'd8, outcome_of(0, 0, 1, 2, 32'd6, 32'd5)));
        plan.push_back(chk_row(REQ_POP_FRONT, 32'h0, outcome_of(1, 0, 1, 1, 32'd5, 32'd5)));
        plan.push_back(chk_row(REQ_POP_BACK, 32'h0, outcome_of(1, 1, 0, 0, EMPTY_VALUE,
                                                               EMPTY_VALUE)));
        // capacity beyond the ring saturates
        plan.push_back(cfg_row(11'd2047));
        plan.push_back(req_row(REQ_PUSH_FRONT, 32'h0000_0001));
        plan.push_back(req_row(REQ_PUSH_BACK, 32'hDEAD_BEEF));
        plan.push_back(req_row(REQ_POP_FRONT, 32'h0));
        plan.push_back(req_row(REQ_POP_BACK, 32'h0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_capacity(plan[i].cap_val);
            else
                offer(plan[i].kind, plan[i].val, plan[i].typed, plan[i].exp);
        end

        run_phase(11'd3, 30, 50, 1'b0, 1'b0);
        run_phase(11'd1, 16, 50, 1'b0, 1'b0);
        run_phase(11'd0, 8, 50, 1'b0, 1'b0);
        run_phase(11'd16, 50, 60, 1'b0, 1'b1);
        // fill the whole ring, then squeeze capacity under the count
        run_phase(11'd2047, 1030, 100, 1'b0, 1'b0);
        run_phase(11'd10, 24, 40, 1'b0, 1'b0);
        run_phase(11'd1024, 24, 55, 1'b1, 1'b0);
        settle();

        if (bad_outcomes == 0)
            $display("bounded_double_ended_queue: match");
        else
            $display("bounded_double_ended_queue: mismatch");
        $finish;
    end

endmodule
